// ===== rtl/nearest_anchor_topk_select_unit_macros.svh =====
// Assertion macros used by the checker file.
`ifndef NEAREST_ANCHOR_TOPK_SELECT_UNIT_MACROS_SVH
`define NEAREST_ANCHOR_TOPK_SELECT_UNIT_MACROS_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define NATS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that an antecedent implies a consequent in the next cycle.
`define NATS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/nats_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package nats_pkg;
  localparam int MAX_DIM_DEF = 1024;
  localparam int MAX_K_DEF = 16;
  localparam int ELEM_W = 16;
  localparam int ID_W = 32;
  localparam int DIST_W = 44;
  localparam int DIM_CFG_W = 11;
  localparam int K_CFG_W = 5;
  localparam int OP_W = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [OP_W-1:0] OP_QUERY = 2'd0;
  localparam logic [OP_W-1:0] OP_ANCHOR = 2'd1;
  localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DIM = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_K = 1'd1;

  localparam logic [DIM_CFG_W-1:0] DIM_RESET = 11'd128;
  localparam logic [K_CFG_W-1:0] K_RESET = 5'd8;

  typedef struct packed {
    logic query_wr;
    logic anchor_step;
    logic anchor_done;
    logic insert;
    logic run_clear;
    logic emit_load;
    logic emit_none;
  } ctrl_t;

  typedef struct packed {
    logic list_empty;
    logic last_elem;
  } stat_t;
endpackage
`default_nettype wire

// ===== rtl/nats_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module nats_datapath #(
  parameter int MAX_DIM = nats_pkg::MAX_DIM_DEF,
  parameter int MAX_K = nats_pkg::MAX_K_DEF
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  nats_pkg::ctrl_t ctrl,
  output nats_pkg::stat_t stat,
  input  wire  logic signed [nats_pkg::ELEM_W-1:0] in_elem,
  input  wire  logic [nats_pkg::ID_W-1:0] in_id,
  input  wire  logic [$clog2(MAX_DIM+1)-1:0] dim_eff,
  input  wire  logic [$clog2(MAX_K+1)-1:0] take,
  output logic [$clog2(MAX_K+1)-1:0] count,
  output logic [$clog2(MAX_K)-1:0] rd_pos,
  output logic [nats_pkg::ID_W-1:0] rd_id,
  output logic [nats_pkg::DIST_W-1:0] rd_dist
);
  import nats_pkg::*;
  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CW = $clog2(MAX_DIM+1);
  localparam int KW = $clog2(MAX_K+1);
  localparam int PW = (MAX_K > 1) ? $clog2(MAX_K) : 1;

  logic signed [ELEM_W-1:0] qmem [MAX_DIM];
  logic [CW-1:0] idx;
  logic [AW-1:0] addr;
  logic signed [ELEM_W-1:0] qrd;
  logic signed [ELEM_W-1:0] elem_s1;
  logic s1_valid, s1_done, s2_valid, s2_done;
  logic s1_clr, s2_clr;
  logic pipe_done;
  logic [2*ELEM_W-1:0] sq;
  logic [DIST_W-1:0] acc;
  logic [DIST_W:0] sum;
  logic [ID_W-1:0] id_s1, id_s2;
  logic signed [ELEM_W:0] diff;
  logic [ELEM_W:0] mag;
  logic last_elem;
  logic [DIST_W-1:0] bd [MAX_K];
  logic [ID_W-1:0] bi [MAX_K];
  logic [MAX_K-1:0] stays_ahead;
  logic [KW-1:0] pos_cnt;
  logic [PW-1:0] emit_pos;

  assign addr = idx[AW-1:0];
  assign last_elem = (idx + CW'(1)) >= dim_eff;

  always_ff @(posedge clk) begin
    if (ctrl.query_wr) begin
      qmem[addr] <= in_elem;
    end
    qrd <= qmem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.run_clear) begin
      idx <= '0;
    end else if (ctrl.query_wr || ctrl.anchor_step) begin
      idx <= last_elem ? '0 : idx + CW'(1);
    end
  end

  // A query element travels down the pipe as a clear slot, so that anchor
  // elements ahead of it still finish and a partial anchor is dropped in order.
  always_ff @(posedge clk) begin
    elem_s1 <= in_elem;
    id_s1 <= in_id;
    id_s2 <= id_s1;
    diff <= (ELEM_W+1)'(elem_s1) - (ELEM_W+1)'(qrd);
    s1_done <= ctrl.anchor_done;
    s2_done <= s1_done;
    if (rst || ctrl.run_clear) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s1_clr <= 1'b0;
      s2_clr <= 1'b0;
    end else begin
      s1_valid <= ctrl.anchor_step;
      s2_valid <= s1_valid;
      s1_clr <= ctrl.query_wr;
      s2_clr <= s1_clr;
    end
  end

  assign mag = diff[ELEM_W] ? (ELEM_W+1)'(-diff) : diff;
  always_comb begin
    sq = mag[ELEM_W-1:0] * mag[ELEM_W-1:0];
    if (mag[ELEM_W]) sq = {1'b1, {(2*ELEM_W-1){1'b0}}};
  end
  assign sum = {1'b0, acc} + (DIST_W+1)'(sq);

  logic [DIST_W-1:0] newd;
  assign newd = sum[DIST_W] ? {DIST_W{1'b1}} : sum[DIST_W-1:0];
  assign pipe_done = s2_valid && s2_done;

  always_ff @(posedge clk) begin
    if (rst || ctrl.run_clear || s2_clr) begin
      acc <= '0;
    end else if (s2_valid) begin
      acc <= s2_done ? '0 : newd;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_K; i++) begin
      stays_ahead[i] = (KW'(i) < count) &&
        !((newd < bd[i]) || ((newd == bd[i]) && (id_s2 < bi[i])));
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert && pipe_done) begin
      for (int i = 0; i < MAX_K; i++) begin
        if (!stays_ahead[i]) begin
          if (i == 0 || stays_ahead[(i == 0) ? 0 : i-1]) begin
            bd[i] <= newd;
            bi[i] <= id_s2;
          end else begin
            bd[i] <= bd[(i == 0) ? 0 : i-1];
            bi[i] <= bi[(i == 0) ? 0 : i-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.run_clear) begin
      count <= '0;
    end else if (ctrl.insert && pipe_done && count < KW'(MAX_K)) begin
      count <= count + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.run_clear) begin
      pos_cnt <= '0;
    end else if (ctrl.emit_load) begin
      pos_cnt <= pos_cnt + KW'(1);
    end
  end
  assign emit_pos = pos_cnt[PW-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.emit_none) begin
      rd_id <= '0;
      rd_dist <= '0;
    end else if (ctrl.emit_load) begin
      rd_id <= bi[emit_pos];
      rd_dist <= bd[emit_pos];
    end
  end
  always_ff @(posedge clk) begin
    if (ctrl.emit_load || ctrl.emit_none) rd_pos <= emit_pos;
  end

  assign stat = '{list_empty: (take == '0), last_elem: last_elem};
endmodule
`default_nettype wire

// ===== rtl/nats_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module nats_ctrl #(
  parameter int MAX_K = nats_pkg::MAX_K_DEF
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  in_fire,
  input  wire  logic [nats_pkg::OP_W-1:0] in_op,
  input  wire  in_usable,
  input  wire  nats_pkg::stat_t stat,
  input  wire  logic [$clog2(MAX_K+1)-1:0] take,
  input  wire  logic [$clog2(MAX_K)-1:0] rd_pos,
  input  wire  out_stall,
  output nats_pkg::ctrl_t ctrl,
  output logic in_stall,
  output logic out_valid,
  output logic out_none,
  output logic out_last
);
  import nats_pkg::*;
  localparam int KW = $clog2(MAX_K+1);
  localparam logic [1:0] S_RUN = 2'd0;
  localparam logic [1:0] S_DRAIN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;
  localparam logic [1:0] S_WAIT = 2'd3;

  logic [1:0] state, state_next;
  logic [2:0] usable_pipe;
  logic issue;

  assign issue = !out_valid || !out_stall;

  always_comb begin
    ctrl = '0;
    state_next = state;
    in_stall = 1'b1;
    case (state)
      S_RUN: begin
        in_stall = 1'b0;
        if (in_fire) begin
          case (in_op)
            OP_QUERY: ctrl.query_wr = 1'b1;
            OP_ANCHOR: begin
              ctrl.anchor_step = 1'b1;
              ctrl.anchor_done = stat.last_elem;
            end
            OP_FINISH: state_next = S_DRAIN;
            default: ;
          endcase
        end
      end
      S_DRAIN: begin
        if (usable_pipe == '0) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (issue) begin
          if (stat.list_empty) begin
            ctrl.emit_none = 1'b1;
          end else begin
            ctrl.emit_load = 1'b1;
          end
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (issue) begin
          if (out_last && out_valid) begin
            ctrl.run_clear = 1'b1;
            state_next = S_RUN;
          end else if (out_valid) begin
            ctrl.emit_load = 1'b1;
          end
        end
      end
      default: state_next = S_RUN;
    endcase
    ctrl.insert = usable_pipe[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
      usable_pipe <= '0;
    end else begin
      state <= state_next;
      usable_pipe <= {usable_pipe[1:0],
                      ctrl.anchor_step & ctrl.anchor_done & in_usable};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_none <= 1'b0;
      out_last <= 1'b0;
    end else if (ctrl.emit_none) begin
      out_valid <= 1'b1;
      out_none <= 1'b1;
      out_last <= 1'b1;
    end else if (ctrl.emit_load) begin
      out_valid <= 1'b1;
      out_none <= 1'b0;
      out_last <= ((state == S_EMIT) ? KW'(1) : KW'(rd_pos) + KW'(2)) == take;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/nearest_anchor_topk_select_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Brute-force k-nearest-anchor selector on squared L2 distance of Q8.8
// vectors. Query and anchor elements, accepted while no report is under
// way, pass through a single multiply-accumulate pipe that reads the query
// memory; a usable anchor's finished distance is inserted into a sorted
// list of up to MAX_K entries by a parallel compare-and-shift. A finish
// request waits for that pipe to drain, then emits one result per reported
// anchor, each after the one before it is taken, or a single empty marker;
// inputs are held off until the last result is taken.
module nearest_anchor_topk_select_unit #(
  parameter int MAX_DIM = nats_pkg::MAX_DIM_DEF,
  parameter int MAX_K = nats_pkg::MAX_K_DEF
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  cfg_valid,
  output logic cfg_ready,
  input  wire  logic [nats_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  logic [31:0] cfg_data,
  input  wire  in_valid,
  output logic in_stall,
  input  wire  logic [nats_pkg::OP_W-1:0] op,
  input  wire  logic signed [nats_pkg::ELEM_W-1:0] element_value,
  input  wire  logic [nats_pkg::ID_W-1:0] anchor_id,
  input  wire  anchor_usable,
  output logic out_valid,
  input  wire  out_stall,
  output logic [nats_pkg::ID_W-1:0] selected_id,
  output logic [nats_pkg::DIST_W-1:0] distance,
  output logic none_found,
  output logic last
);
  import nats_pkg::*;
  localparam int CW = $clog2(MAX_DIM+1);
  localparam int KW = $clog2(MAX_K+1);
  localparam int PW = (MAX_K > 1) ? $clog2(MAX_K) : 1;

  logic [DIM_CFG_W-1:0] dim_reg;
  logic [K_CFG_W-1:0] k_reg;
  logic [CW-1:0] dim_eff;
  logic [KW-1:0] k_eff, take, count;
  logic [PW-1:0] rd_pos;
  logic in_fire;
  ctrl_t ctrl;
  stat_t stat;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_reg <= DIM_RESET;
      k_reg <= K_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DIM: dim_reg <= cfg_data[DIM_CFG_W-1:0];
        REG_K: k_reg <= cfg_data[K_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (dim_reg == '0) dim_eff = CW'(1);
    else if (32'(dim_reg) > 32'(MAX_DIM)) dim_eff = CW'(MAX_DIM);
    else dim_eff = CW'(dim_reg);
    if (32'(k_reg) > 32'(MAX_K)) k_eff = KW'(MAX_K);
    else k_eff = KW'(k_reg);
    take = (k_eff < count) ? k_eff : count;
  end

  assign in_fire = in_valid && !in_stall;

  nats_datapath #(.MAX_DIM(MAX_DIM), .MAX_K(MAX_K)) u_dp (
    .clk, .rst, .ctrl, .stat, .in_elem(element_value), .in_id(anchor_id),
    .dim_eff, .take, .count, .rd_pos, .rd_id(selected_id),
    .rd_dist(distance)
  );

  nats_ctrl #(.MAX_K(MAX_K)) u_ctrl (
    .clk, .rst, .in_fire, .in_op(op), .in_usable(anchor_usable),
    .stat, .take, .rd_pos, .out_stall, .ctrl, .in_stall, .out_valid,
    .out_none(none_found), .out_last(last)
  );
endmodule
`default_nettype wire

// ===== rtl/nats_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_anchor_topk_select_unit_macros.svh"
module nats_checker (
  input wire clk,
  input wire rst,
  input wire in_stall,
  input wire out_valid,
  input wire out_stall,
  input wire none_found,
  input wire last,
  input wire [43:0] distance
);
  `NATS_ASSERT_SAME(a_none_last, clk, rst, out_valid && none_found, last, "empty marker not last")
  `NATS_ASSERT_SAME(a_none_zero, clk, rst, out_valid && none_found, distance == 44'd0, "empty marker distance")
  `NATS_ASSERT_SAME(a_no_overlap, clk, rst, out_valid, in_stall, "input open during report")
  `NATS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "result dropped under stall")
endmodule

bind nearest_anchor_topk_select_unit nats_checker u_nats_checker (
  .clk, .rst, .in_stall, .out_valid, .out_stall, .none_found,
  .last, .distance
);
`default_nettype wire

// ===== tb/nearest_anchor_topk_select_unit_tb.sv =====
`timescale 1ns / 1ps
module nearest_anchor_topk_select_unit_tb;
  import nats_pkg::*;

  localparam int MAX_DIM = MAX_DIM_DEF;
  localparam int MAX_K = MAX_K_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
  localparam logic [DIST_W-1:0] DIST_SAT = {DIST_W{1'b1}};

  typedef struct {
    logic [OP_W-1:0] op;
    logic signed [ELEM_W-1:0] elem;
    logic [ID_W-1:0] id;
    logic usable;
  } request_t;

  typedef struct {
    logic [ID_W-1:0] id;
    logic [DIST_W-1:0] dval;
    logic none;
    logic fin;
  } neighbor_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] op = '0;
  logic signed [ELEM_W-1:0] element_value = '0;
  logic [ID_W-1:0] anchor_id = '0;
  logic anchor_usable = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ID_W-1:0] selected_id;
  logic [DIST_W-1:0] distance;
  logic none_found;
  logic last;

  nearest_anchor_topk_select_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .element_value(element_value),
    .anchor_id(anchor_id), .anchor_usable(anchor_usable),
    .out_valid(out_valid), .out_stall(out_stall), .selected_id(selected_id),
    .distance(distance), .none_found(none_found), .last(last)
  );

  always #5 clk = ~clk;

  request_t pending_q[$];
  neighbor_t neighbor_q[$];
  int errors = 0;
  int requests_taken = 0;
  int neighbors_seen = 0;
  int cycles = 0;
  bit no_idle = 0;

  // Predictor state.
  logic [DIM_CFG_W-1:0] dim_reg = DIM_RESET;
  logic [K_CFG_W-1:0] k_reg = K_RESET;
  logic signed [ELEM_W-1:0] query_mem[MAX_DIM];
  int unsigned elem_idx = 0;
  logic [DIST_W-1:0] dist_acc = '0;
  logic [DIST_W-1:0] best_dist[MAX_K];
  logic [ID_W-1:0] best_id[MAX_K];
  int unsigned best_n = 0;

  // Stimulus-side tracking, so that no unwritten query entry is ever read.
  bit query_written[MAX_DIM];
  int unsigned gen_idx = 0;

  function automatic int unsigned dim_eff(logic [DIM_CFG_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return d;
  endfunction

  function automatic void insert_neighbor(logic [DIST_W-1:0] d, logic [ID_W-1:0] id);
    int unsigned pos;
    int unsigned i;
    pos = 0;
    while (pos < best_n && pos < MAX_K &&
           !(d < best_dist[pos] || (d == best_dist[pos] && id < best_id[pos])))
      pos++;
    if (pos >= MAX_K) return;
    i = (best_n < MAX_K) ? best_n : MAX_K - 1;
    while (i > pos) begin
      best_dist[i] = best_dist[i-1];
      best_id[i] = best_id[i-1];
      i--;
    end
    best_dist[pos] = d;
    best_id[pos] = id;
    if (best_n < MAX_K) best_n++;
  endfunction

  function automatic void predict_request(request_t r);
    int unsigned idx;
    int unsigned kk;
    int unsigned take;
    bit done;
    int diff;
    longint unsigned sq;
    longint unsigned sum;
    neighbor_t n;
    idx = (elem_idx >= MAX_DIM) ? 0 : elem_idx;
    done = (idx + 1 >= dim_eff(dim_reg));
    case (r.op)
      OP_QUERY: begin
        dist_acc = '0;
        query_mem[idx] = r.elem;
        elem_idx = done ? 0 : idx + 1;
      end
      OP_ANCHOR: begin
        diff = int'(r.elem) - int'(query_mem[idx]);
        sq = longint'(diff) * longint'(diff);
        sum = longint'(dist_acc) + sq;
        dist_acc = (sum > longint'(DIST_SAT)) ? DIST_SAT : sum[DIST_W-1:0];
        if (done) begin
          if (r.usable) insert_neighbor(dist_acc, r.id);
          dist_acc = '0;
          elem_idx = 0;
        end else begin
          elem_idx = idx + 1;
        end
      end
      OP_FINISH: begin
        kk = (k_reg > MAX_K) ? MAX_K : k_reg;
        take = (kk < best_n) ? kk : best_n;
        if (take == 0) begin
          n.id = '0; n.dval = '0; n.none = 1'b1; n.fin = 1'b1;
          neighbor_q = {neighbor_q, n};
        end
        for (int unsigned j = 0; j < take; j++) begin
          n.id = best_id[j]; n.dval = best_dist[j]; n.none = 1'b0;
          n.fin = (j + 1 == take);
          neighbor_q = {neighbor_q, n};
        end
        elem_idx = 0;
        dist_acc = '0;
        best_n = 0;
      end
      default: ;
    endcase
  endfunction

  // Request driver.
  request_t cur;
  int unsigned in_gap = 0;
  always @(posedge clk) begin
    logic nv;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      nv = in_valid;
      if (in_valid && !in_stall) begin
        predict_request(cur);
        requests_taken++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_q.size() > 0) begin
          cur = pending_q.pop_front();
          op <= cur.op;
          element_value <= cur.elem;
          anchor_id <= cur.id;
          anchor_usable <= cur.usable;
          nv = 1'b1;
          in_gap = no_idle ? 0 : $urandom_range(0, 10);
        end
      end
      in_valid <= nv;
    end
  end

  // Result monitor.
  int unsigned out_hold = 0;
  always @(posedge clk) begin
    neighbor_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        neighbors_seen++;
        if (neighbor_q.size() == 0) begin
          $error("unexpected result: selected_id %0h distance %0h", selected_id, distance);
          errors++;
        end else begin
          e = neighbor_q.pop_front();
          if (selected_id !== e.id) begin
            $error("selected_id expected %0h actual %0h", e.id, selected_id);
            errors++;
          end
          if (distance !== e.dval) begin
            $error("distance expected %0h actual %0h", e.dval, distance);
            errors++;
          end
          if (none_found !== e.none) begin
            $error("none_found expected %0b actual %0b", e.none, none_found);
            errors++;
          end
          if (last !== e.fin) begin
            $error("last expected %0b actual %0b", e.fin, last);
            errors++;
          end
        end
        out_hold = no_idle ? 0 : $urandom_range(0, 10);
      end else if (out_hold > 0) begin
        out_hold--;
      end
      out_stall <= (out_hold > 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_DIM) dim_reg = data[DIM_CFG_W-1:0];
    else k_reg = data[K_CFG_W-1:0];
  endtask

  task automatic push_request(logic [OP_W-1:0] o, logic [15:0] v, logic [31:0] id,
                              logic us);
    request_t r;
    int unsigned dd;
    dd = dim_eff(dim_reg);
    if (o == OP_ANCHOR && !query_written[gen_idx]) o = OP_QUERY;
    r.op = o; r.elem = v; r.id = id; r.usable = us;
    pending_q = {pending_q, r};
    case (o)
      OP_QUERY: begin
        query_written[gen_idx] = 1;
        gen_idx = (gen_idx + 1 >= dd) ? 0 : gen_idx + 1;
      end
      OP_ANCHOR: gen_idx = (gen_idx + 1 >= dd) ? 0 : gen_idx + 1;
      OP_FINISH: gen_idx = 0;
      default: ;
    endcase
  endtask

  task automatic push_anchor(logic [15:0] a, logic [15:0] b, logic [31:0] id, logic us);
    push_request(OP_ANCHOR, a, $urandom, 1'($urandom_range(0, 1)));
    push_request(OP_ANCHOR, b, id, us);
  endtask

  task automatic wait_idle();
    while (pending_q.size() > 0 || in_valid || neighbor_q.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_elem();
    if ($urandom_range(0, 2) == 0) return 16'($signed($urandom_range(0, 2)) - 1);
    return 16'($urandom);
  endfunction

  initial begin
    int rand_items;
    int phases;
    int unsigned dd;
    int unsigned n_anch;
    bit need_query;
    int dims[7];
    int ks[7];
    dims = '{1, 0, 3, 2, 4, 7, 16};
    ks = '{16, 0, 31, 1, 5, 8, 3};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, ties, an unusable anchor, a dropped partial anchor.
    write_reg(REG_DIM, 32'hFFFF_F802);
    write_reg(REG_K, 32'hFFFF_FFF0);
    push_request(OP_QUERY, 16'h7FFF, '0, 1'b0);
    push_request(OP_QUERY, 16'h8000, 32'hFFFF_FFFF, 1'b1);
    push_anchor(16'h8000, 16'h7FFF, 32'hFFFF_FFFF, 1'b1);
    push_anchor(16'h7FFF, 16'h8000, 32'd5, 1'b1);
    push_anchor(16'h7FFF, 16'h8000, 32'd3, 1'b0);
    push_anchor(16'h0000, 16'h0000, 32'd7, 1'b1);
    push_anchor(16'h0000, 16'h0000, 32'd2, 1'b1);
    push_request(OP_ANCHOR, 16'd100, 32'd9, 1'b1);
    push_request(OP_QUERY, 16'h8000, 32'd9, 1'b1);
    push_request(OP_IGNORED, 16'h1234, 32'd11, 1'b1);
    push_request(OP_FINISH, '0, '0, 1'b0);
    push_request(OP_FINISH, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    wait_idle();

    // Random phases over several settings.
    rand_items = 0;
    phases = 0;
    while (rand_items < 100) begin
      if (phases < 7) begin
        write_reg(REG_DIM, dims[phases]);
        write_reg(REG_K, ks[phases]);
      end else begin
        write_reg(REG_DIM, $urandom_range(0, 6) | ($urandom & 32'hFFFF_F800));
        write_reg(REG_K, ($urandom_range(0, 4) == 0) ? $urandom_range(17, 31)
                                                     : $urandom_range(0, 16));
      end
      no_idle = ($urandom_range(0, 3) == 0);
      dd = dim_eff(dim_reg);
      need_query = 0;
      for (int i = 0; i < dd; i++) if (!query_written[i]) need_query = 1;
      if (need_query || $urandom_range(0, 9) < 7) begin
        for (int i = 0; i < dd; i++)
          push_request(OP_QUERY, rand_elem(), $urandom, 1'($urandom));
        rand_items += dd;
      end
      n_anch = $urandom_range(0, 20);
      for (int a = 0; a < n_anch; a++) begin
        if ($urandom_range(0, 9) == 0) begin
          push_request(OP_W'($urandom_range(0, 3)), 16'($urandom), $urandom,
                       1'($urandom));
          rand_items++;
        end
        for (int i = 0; i < dd; i++)
          push_request(OP_ANCHOR, rand_elem(),
                       ($urandom_range(0, 1) == 0) ? $urandom_range(0, 7) : $urandom,
                       ($urandom_range(0, 3) != 0));
        rand_items += dd;
      end
      push_request(OP_FINISH, 16'($urandom), $urandom, 1'($urandom));
      rand_items++;
      phases++;
      wait_idle();
    end

    repeat (20) @(posedge clk);
    $display("Ran %0d requests over %0d random phases plus a directed run,",
             requests_taken, phases);
    $display("and checked %0d results.", neighbors_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== nearest_anchor_topk_select_unit.f =====
+incdir+rtl
rtl/nats_pkg.sv
rtl/nats_datapath.sv
rtl/nats_ctrl.sv
rtl/nearest_anchor_topk_select_unit.sv
rtl/nats_checker.sv
tb/nearest_anchor_topk_select_unit_tb.sv
